/* src/assert_macros.svh */
// Assertion helpers shared by the RTL. Synthesis builds define SYNTH.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold on every clock edge outside reset.
`define PHG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define PHG_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PHG_ASSERT(label, clk, rst_n, prop, msg)
`define PHG_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

/* src/phg_pkg.sv */
`default_nettype none

package phg_pkg;

    // Field widths
    localparam int TS_W      = 33;
    localparam int PLEN_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int SID_W     = 8;
    localparam int S_TDATA_W = ((TS_W + PLEN_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_VIDEO_SID = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUDIO_SID = 1'd1;
    localparam logic [SID_W-1:0] VIDEO_SID_RST = 8'hE0;
    localparam logic [SID_W-1:0] AUDIO_SID_RST = 8'hC0;

    // Stream kinds
    localparam logic KIND_VIDEO = 1'b0;
    localparam logic KIND_AUDIO = 1'b1;

    // Header lengths and byte positions
    localparam int VIDEO_LEN = 25;
    localparam int AUDIO_LEN = 14;
    localparam int IDX_W     = $clog2(VIDEO_LEN);
    localparam logic [IDX_W-1:0] VIDEO_LAST_IDX = IDX_W'(VIDEO_LEN - 1);
    localparam logic [IDX_W-1:0] AUDIO_LAST_IDX = IDX_W'(AUDIO_LEN - 1);

    // Timestamp prefixes
    localparam logic [3:0] PFX_PTS_ONLY = 4'h2;
    localparam logic [3:0] PFX_PTS      = 4'h3;
    localparam logic [3:0] PFX_DTS      = 4'h1;

    // Queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // One classified request
    typedef struct packed {
        logic              kind;
        logic [SID_W-1:0]  sid;
        logic [PLEN_W-1:0] pes_len;
        logic [TS_W-1:0]   ts;
    } t_desc;

    // Sequencer status seen by the top level
    typedef struct packed {
        logic             at_last;
        logic [IDX_W-1:0] idx;
    } t_back_stat;

    // One of the five bytes of a coded timestamp
    function automatic logic [BYTE_W-1:0] stamp_byte(
        input logic [3:0]      pfx,
        input logic [TS_W-1:0] ts,
        input logic [2:0]      k
    );
        logic [BYTE_W-1:0] b;
        unique case (k)
            3'd0:    b = {pfx, ts[32:30], 1'b1};
            3'd1:    b = ts[29:22];
            3'd2:    b = {ts[21:15], 1'b1};
            3'd3:    b = ts[14:7];
            3'd4:    b = {ts[6:0], 1'b1};
            default: b = '0;
        endcase
        return b;
    endfunction

    // Header byte at position idx for a request
    function automatic logic [BYTE_W-1:0] hdr_byte(
        input t_desc            d,
        input logic [IDX_W-1:0] idx
    );
        logic              vid;
        logic [BYTE_W-1:0] b;
        vid = (d.kind == KIND_VIDEO);
        unique case (idx)
            5'd0, 5'd1: b = 8'h00;
            5'd2:       b = 8'h01;
            5'd3:       b = d.sid;
            5'd4:       b = d.pes_len[15:8];
            5'd5:       b = d.pes_len[7:0];
            5'd6:       b = 8'h84;
            5'd7:       b = vid ? 8'hC0 : 8'h80;
            5'd8:       b = vid ? 8'h0A : 8'h05;
            5'd9:       b = stamp_byte(vid ? PFX_PTS : PFX_PTS_ONLY, d.ts, 3'd0);
            5'd10:      b = stamp_byte(vid ? PFX_PTS : PFX_PTS_ONLY, d.ts, 3'd1);
            5'd11:      b = stamp_byte(vid ? PFX_PTS : PFX_PTS_ONLY, d.ts, 3'd2);
            5'd12:      b = stamp_byte(vid ? PFX_PTS : PFX_PTS_ONLY, d.ts, 3'd3);
            5'd13:      b = stamp_byte(vid ? PFX_PTS : PFX_PTS_ONLY, d.ts, 3'd4);
            5'd14:      b = stamp_byte(PFX_DTS, d.ts, 3'd0);
            5'd15:      b = stamp_byte(PFX_DTS, d.ts, 3'd1);
            5'd16:      b = stamp_byte(PFX_DTS, d.ts, 3'd2);
            5'd17:      b = stamp_byte(PFX_DTS, d.ts, 3'd3);
            5'd18:      b = stamp_byte(PFX_DTS, d.ts, 3'd4);
            // access unit delimiter NAL
            5'd19, 5'd20, 5'd21: b = 8'h00;
            5'd22:      b = 8'h01;
            5'd23:      b = 8'h09;
            5'd24:      b = 8'hF0;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* src/pes_header_generator.sv */
`default_nettype none

// PES header generator. Each request (stream kind, 33-bit PTS, payload
// length) produces one PES header on the output stream, one byte per
// transaction, tlast on the final byte: 25 bytes for video (PTS, equal DTS
// and an access unit delimiter) and 14 bytes for audio (PTS only, length
// payload+8 saturating at 65535). The byte sequencer sends one byte per
// cycle while the output is not stalled; requests are taken every cycle
// while the two-entry queue behind the intake stage has room. Stream ids
// are set through the write port (index 0 video, 1 audio); the user must
// do so only while the block is idle, which the block does not enforce.
module pes_header_generator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [32:0] timestamp, [48:33] payload_length, [55:49] zero
    input  wire logic [phg_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [0] stream_kind
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [7:0] header_byte
    output logic [phg_pkg::BYTE_W-1:0]          m_axis_tdata,
    output logic                                m_axis_tlast,
    input  wire logic                           i_cfg_wen,
    input  wire logic [phg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [phg_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import phg_pkg::*;

    logic               w_push_valid;
    logic               w_push_ready;
    t_desc              w_front_desc;
    t_desc              w_head;
    logic               w_head_valid;
    logic               w_pop;
    logic [FIFO_CW-1:0] w_fifo_cnt;
    t_back_stat         w_stat;
    logic               w_end_pos;

    phg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .o_s_tready   (s_axis_tready),
        .i_kind       (s_axis_tuser),
        .i_ts         (s_axis_tdata[TS_W-1:0]),
        .i_plen       (s_axis_tdata[TS_W+PLEN_W-1:TS_W]),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_desc       (w_front_desc)
    );

    phg_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_desc       (w_front_desc),
        .o_pop_valid  (w_head_valid),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_cnt        (w_fifo_cnt)
    );

    phg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_head_valid),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast),
        .o_stat     (w_stat)
    );

    // Sequencer position is one of the two header ends
    assign w_end_pos = (w_stat.idx == VIDEO_LAST_IDX) || (w_stat.idx == AUDIO_LAST_IDX);

`include "assert_macros.svh"

    // Queue never overfills, never pops empty
    `PHG_NEVER(a_fifo_over, i_clk, i_rst_n, w_fifo_cnt > FIFO_CW'(FIFO_DEPTH), "queue overfilled")
    `PHG_ASSERT(a_pop_nonempty, i_clk, i_rst_n, w_pop |-> w_head_valid, "pop of empty queue")
    // Request retires only on its final header byte
    `PHG_ASSERT(a_pop_at_end, i_clk, i_rst_n, w_pop |-> w_stat.at_last, "pop before last byte")
    `PHG_ASSERT(a_last_pos, i_clk, i_rst_n, w_stat.at_last |-> w_end_pos, "bad last position")

endmodule

`default_nettype wire

/* src/phg_front.sv */
`default_nettype none

// Request intake: holds the stream id registers, classifies each request
// and hands a descriptor to the queue.
module phg_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic                           i_kind,
    input  wire logic [phg_pkg::TS_W-1:0]       i_ts,
    input  wire logic [phg_pkg::PLEN_W-1:0]     i_plen,
    input  wire logic                           i_cfg_wen,
    input  wire logic [phg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [phg_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                                o_push_valid,
    input  wire logic                           i_push_ready,
    output phg_pkg::t_desc                      o_desc
);
    import phg_pkg::*;

    logic [SID_W-1:0]  r_video_sid;
    logic [SID_W-1:0]  r_audio_sid;
    logic              r_valid;
    t_desc             r_desc;
    t_desc             n_desc;
    logic [PLEN_W:0]   w_sum;
    logic              w_load;

    // Stream id registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_sid <= VIDEO_SID_RST;
            r_audio_sid <= AUDIO_SID_RST;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                REG_VIDEO_SID: r_video_sid <= i_cfg_wdata[SID_W-1:0];
                REG_AUDIO_SID: r_audio_sid <= i_cfg_wdata[SID_W-1:0];
                default:       ;
            endcase
        end
    end

    // Classification: id, zero video length and saturated audio length
    always_comb begin
        w_sum          = {1'b0, i_plen} + (PLEN_W+1)'(8);
        n_desc.kind    = i_kind;
        n_desc.ts      = i_ts;
        if (i_kind == KIND_VIDEO) begin
            n_desc.sid     = r_video_sid;
            n_desc.pes_len = '0;
        end else begin
            n_desc.sid     = r_audio_sid;
            n_desc.pes_len = w_sum[PLEN_W] ? {PLEN_W{1'b1}} : w_sum[PLEN_W-1:0];
        end
    end

    assign o_s_tready   = !r_valid || i_push_ready;
    assign w_load       = i_s_tvalid && o_s_tready;
    assign o_push_valid = r_valid;
    assign o_desc       = r_desc;

    // Descriptor stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_desc <= n_desc;
        end
    end

endmodule

`default_nettype wire

/* src/phg_fifo.sv */
`default_nettype none

// Short descriptor queue between intake and byte sequencer.
module phg_fifo (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push_valid,
    output logic                              o_push_ready,
    input  wire phg_pkg::t_desc               i_desc,
    output logic                              o_pop_valid,
    input  wire logic                         i_pop,
    output phg_pkg::t_desc                    o_head,
    output logic [phg_pkg::FIFO_CW-1:0]       o_cnt
);
    import phg_pkg::*;

    t_desc              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr;
    logic [FIFO_AW-1:0] r_rptr;
    logic [FIFO_CW-1:0] r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_push_ready = (r_cnt != FIFO_CW'(FIFO_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;
    assign o_head       = r_mem[r_rptr];
    assign o_cnt        = r_cnt;

    function automatic logic [FIFO_AW-1:0] ptr_inc(input logic [FIFO_AW-1:0] p);
        return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) r_wptr <= ptr_inc(r_wptr);
            if (w_pop)  r_rptr <= ptr_inc(r_rptr);
            if (w_push && !w_pop)      r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

endmodule

`default_nettype wire

/* src/phg_back.sv */
`default_nettype none

// Byte sequencer: walks the head descriptor into the output register one
// byte per cycle unless stalled, popping the queue on the final byte.
module phg_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire phg_pkg::t_desc            i_head,
    output logic                           o_pop,
    output logic                           o_m_tvalid,
    input  wire logic                      i_m_tready,
    output logic [phg_pkg::BYTE_W-1:0]     o_m_tdata,
    output logic                           o_m_tlast,
    output phg_pkg::t_back_stat            o_stat
);
    import phg_pkg::*;

    logic [IDX_W-1:0]  r_idx;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              w_adv;
    logic              w_emit;
    logic              w_last;

    assign w_adv  = !r_out_valid || i_m_tready;
    assign w_emit = i_valid && w_adv;
    assign w_last = (i_head.kind == KIND_VIDEO) ? (r_idx == VIDEO_LAST_IDX)
                                                : (r_idx == AUDIO_LAST_IDX);
    assign o_pop  = w_emit && w_last;

    // Position counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (w_adv)  r_out_valid <= i_valid;
            if (w_emit) r_idx       <= w_last ? '0 : r_idx + 1'b1;
        end
    end

    // Output byte register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_byte <= hdr_byte(i_head, r_idx);
            r_last <= w_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_byte;
    assign o_m_tlast  = r_last;
    assign o_stat     = '{at_last: w_last, idx: r_idx};

endmodule

`default_nettype wire

/* bench/pes_header_generator_tb.sv */
`default_nettype none

module pes_header_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Run limits
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 36;

    // Timestamp prefix nibbles
    localparam logic [3:0] PREFIX_PTS_ONLY = 4'h2;
    localparam logic [3:0] PREFIX_PTS      = 4'h3;
    localparam logic [3:0] PREFIX_DTS      = 4'h1;

    // Reset values of the stream id registers
    localparam logic [7:0] VIDEO_SID_DEFAULT = 8'hE0;
    localparam logic [7:0] AUDIO_SID_DEFAULT = 8'hC0;

    localparam logic [32:0] TS_MAX   = 33'h1_FFFF_FFFF;
    localparam logic [15:0] PLEN_MAX = 16'hFFFF;

    typedef struct {
        logic        kind;
        logic [32:0] ts;
        logic [15:0] plen;
    } t_frame_req;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_hdr_beat;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    // [32:0] timestamp, [48:33] payload_length, [55:49] zero
    logic [phg_pkg::S_TDATA_W-1:0]       s_axis_tdata  = '0;
    // [0] stream_kind
    logic                                s_axis_tuser  = 1'b0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    // [7:0] header_byte
    logic [phg_pkg::BYTE_W-1:0]          m_axis_tdata;
    logic                                m_axis_tlast;
    logic                                i_cfg_wen     = 1'b0;
    logic [phg_pkg::CFG_IDX_W-1:0]       i_cfg_idx     = '0;
    logic [phg_pkg::CFG_DATA_W-1:0]      i_cfg_wdata   = '0;

    t_frame_req frame_req_q[$];
    t_hdr_beat  hdr_beat_q[$];

    // predictor copy of the stream id registers
    logic [7:0] video_sid;
    logic [7:0] audio_sid;

    t_hdr_beat  want_beat;
    t_frame_req next_req;
    logic       req_taken   = 1'b0;
    bit         idle_en     = 1'b1;
    int         src_gap     = 0;
    int         sink_gap    = 0;
    int         mismatch_cnt = 0;
    int         cycle_cnt   = 0;

    pes_header_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Five coded timestamp bytes, first byte in the top bits
    function automatic logic [39:0] pack_timestamp(input logic [3:0] pfx,
                                                   input logic [32:0] ts);
        return {pfx, ts[32:30], 1'b1, ts[29:22], ts[21:15], 1'b1,
                ts[14:7], ts[6:0], 1'b1};
    endfunction

    // Expected header bytes of one request, appended to the byte queue
    task automatic predict_pes_header(input t_frame_req req);
        logic [7:0]  hdr[$];
        logic [16:0] pes_len;
        logic [39:0] pts;
        logic [39:0] dts;
        hdr = {8'h00, 8'h00, 8'h01};
        if (req.kind == phg_pkg::KIND_VIDEO) begin
            pts = pack_timestamp(PREFIX_PTS, req.ts);
            dts = pack_timestamp(PREFIX_DTS, req.ts);
            // unbounded length, PTS+DTS flags, 10 header bytes
            hdr = {hdr, video_sid, 8'h00, 8'h00, 8'h84, 8'hC0, 8'h0A};
            for (int k = 4; k >= 0; k--) hdr.push_back(pts[k*8 +: 8]);
            for (int k = 4; k >= 0; k--) hdr.push_back(dts[k*8 +: 8]);
            // access unit delimiter
            hdr = {hdr, 8'h00, 8'h00, 8'h00, 8'h01, 8'h09, 8'hF0};
        end else begin
            pts = pack_timestamp(PREFIX_PTS_ONLY, req.ts);
            pes_len = {1'b0, req.plen} + 17'd8;
            if (pes_len > 17'h0FFFF) pes_len = 17'h0FFFF;
            hdr = {hdr, audio_sid, pes_len[15:8], pes_len[7:0], 8'h84, 8'h80, 8'h05};
            for (int k = 4; k >= 0; k--) hdr.push_back(pts[k*8 +: 8]);
        end
        foreach (hdr[i]) hdr_beat_q.push_back('{data: hdr[i], last: i == hdr.size() - 1});
    endtask

    // Sender: one request per transaction, random idle bursts
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && !req_taken) begin
                // hold until taken
            end else if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (frame_req_q.size() > 0) begin
                if (idle_en && $urandom_range(3, 0) == 0) begin
                    src_gap = $urandom_range(17, 1) - 1;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    next_req = frame_req_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'b0, next_req.plen, next_req.ts};
                    s_axis_tuser  <= next_req.kind;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
            req_taken = 1'b0;
        end
    end

    // Receiver: backpressure in random bursts
    always @(negedge i_clk) begin
        if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else if (idle_en && $urandom_range(7, 0) == 0) begin
            sink_gap = $urandom_range(17, 1) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: mirror register writes, predict on input, check output
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            video_sid = VIDEO_SID_DEFAULT;
            audio_sid = AUDIO_SID_DEFAULT;
        end else begin
            if (i_cfg_wen) begin
                if (i_cfg_idx == phg_pkg::REG_VIDEO_SID) video_sid = i_cfg_wdata;
                else if (i_cfg_idx == phg_pkg::REG_AUDIO_SID) audio_sid = i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                req_taken = 1'b1;
                predict_pes_header('{kind: s_axis_tuser, ts: s_axis_tdata[32:0],
                                     plen: s_axis_tdata[48:33]});
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (hdr_beat_q.size() == 0) begin
                    $display("%0t: unexpected byte: expected none, actual %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                    mismatch_cnt++;
                end else begin
                    want_beat = hdr_beat_q.pop_front();
                    if (m_axis_tdata !== want_beat.data) begin
                        $display("%0t: header_byte mismatch: expected %h, actual %h",
                                 $time, want_beat.data, m_axis_tdata);
                        mismatch_cnt++;
                    end
                    if (m_axis_tlast !== want_beat.last) begin
                        $display("%0t: last_byte mismatch: expected %b, actual %b",
                                 $time, want_beat.last, m_axis_tlast);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("pes_header_generator regression: fail");
            $finish;
        end
    end

    task automatic add_req(input logic kind, input logic [32:0] ts, input logic [15:0] plen);
        frame_req_q.push_back('{kind: kind, ts: ts, plen: plen});
    endtask

    // Block idle: nothing queued, nothing offered, every byte received
    task automatic wait_drained();
        @(posedge i_clk);
        #1;
        while (frame_req_q.size() > 0 || s_axis_tvalid || hdr_beat_q.size() > 0) begin
            @(posedge i_clk);
            #1;
        end
    endtask

    task automatic write_reg(input logic [phg_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_random_reqs(input int count);
        logic [32:0] ts;
        logic [15:0] plen;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(7, 0))
                0:       ts = '0;
                1:       ts = TS_MAX;
                default: ts = {1'($urandom_range(1, 0)), 32'($urandom())};
            endcase
            case ($urandom_range(3, 0))
                0:       plen = 16'($urandom_range(64, 0));
                1:       plen = 16'($urandom_range(65535, 65520));
                default: plen = 16'($urandom());
            endcase
            add_req(1'($urandom_range(1, 0)), ts, plen);
        end
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: timestamp and length extremes at reset ids
        add_req(phg_pkg::KIND_VIDEO, '0, '0);
        add_req(phg_pkg::KIND_VIDEO, TS_MAX, PLEN_MAX);
        add_req(phg_pkg::KIND_AUDIO, '0, '0);
        add_req(phg_pkg::KIND_AUDIO, TS_MAX, 16'd65527);   // length exactly 65535
        add_req(phg_pkg::KIND_AUDIO, 33'h0_AAAA_AAAA, 16'd65528); // saturates
        add_req(phg_pkg::KIND_AUDIO, 33'h1_5555_5555, PLEN_MAX);
        add_req(phg_pkg::KIND_VIDEO, 33'h0_AAAA_AAAA, 16'hAAAA);
        add_req(phg_pkg::KIND_VIDEO, 33'h1_5555_5555, 16'h5555);
        add_req(phg_pkg::KIND_AUDIO, 33'h1_0000_0001, 16'hAAAA);
        add_req(phg_pkg::KIND_AUDIO, 33'h0_FFFF_FFFE, 16'h5555);
        wait_drained();

        // Top of the nominal id ranges
        write_reg(phg_pkg::REG_VIDEO_SID, 8'hEF);
        write_reg(phg_pkg::REG_AUDIO_SID, 8'hDF);
        add_req(phg_pkg::KIND_VIDEO, 33'h1_2345_6789, 16'd100);
        add_req(phg_pkg::KIND_AUDIO, 33'h0_8765_4321, 16'd100);
        add_req(phg_pkg::KIND_AUDIO, TS_MAX, 16'd65530);
        wait_drained();

        // Ids outside the nominal ranges go out unchanged
        write_reg(phg_pkg::REG_VIDEO_SID, 8'h00);
        write_reg(phg_pkg::REG_AUDIO_SID, 8'hFF);
        add_req(phg_pkg::KIND_VIDEO, '0, PLEN_MAX);
        add_req(phg_pkg::KIND_AUDIO, '0, 16'd7);
        add_req(phg_pkg::KIND_VIDEO, TS_MAX, 16'd0);
        add_req(phg_pkg::KIND_AUDIO, 33'h1_FFFF_0000, 16'd65529);
        wait_drained();

        // Random phases; the second and the last run without idling
        for (int ph = 0; ph < 4; ph++) begin
            idle_en = (ph == 0 || ph == 2);
            case (ph)
                0: begin
                    write_reg(phg_pkg::REG_VIDEO_SID, 8'($urandom_range(239, 224)));
                    write_reg(phg_pkg::REG_AUDIO_SID, 8'($urandom_range(223, 192)));
                end
                1: begin
                    write_reg(phg_pkg::REG_VIDEO_SID, 8'hFF);
                    write_reg(phg_pkg::REG_AUDIO_SID, 8'h00);
                end
                2: begin
                    write_reg(phg_pkg::REG_VIDEO_SID, 8'($urandom()));
                    write_reg(phg_pkg::REG_AUDIO_SID, 8'($urandom()));
                end
                default: begin
                    write_reg(phg_pkg::REG_VIDEO_SID, VIDEO_SID_DEFAULT);
                    write_reg(phg_pkg::REG_AUDIO_SID, AUDIO_SID_DEFAULT);
                end
            endcase
            add_random_reqs(PHASE_ITEMS);
            wait_drained();
        end

        // Nothing more may come out
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && hdr_beat_q.size() == 0) begin
            $display("pes_header_generator regression: pass");
        end else begin
            $display("pes_header_generator regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
